@@ hw/rtl/bat_pkg.sv @@
// Shared types, codes and microcode for the bump allocator block table.
// Used by bat_useq, bat_dpath and bump_allocator_block_table_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

  localparam int FIELD_W = 17;
  localparam int UPC_W   = 4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_ALLOC     = 4'd2,
    OP_RD_FIRST  = 4'd3,
    OP_SCAN      = 4'd4,
    OP_RD_NEXT   = 4'd5,
    OP_SHIFT     = 4'd6,
    OP_FREE_OK   = 4'd7,
    OP_FREE_MISS = 4'd8,
    OP_EMIT      = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_IN_BEAT  = 4'd2,
    C_IS_FREE  = 4'd3,
    C_CNT_ZERO = 4'd4,
    C_SCAN_END = 4'd5,
    C_NO_HIT   = 4'd6,
    C_LAST1    = 4'd7,
    C_LAST2    = 4'd8,
    C_OUT_FREE = 4'd9
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             seq;
    logic [UPC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_beat;
    logic is_free;
    logic cnt_zero;
    logic scan_end;
    logic no_hit;
    logic last1;
    logic last2;
    logic out_free;
  } flags_t;

  localparam logic [UPC_W-1:0] S_WAIT      = 4'd0;
  localparam logic [UPC_W-1:0] S_DISPATCH  = 4'd1;
  localparam logic [UPC_W-1:0] S_ALLOC     = 4'd2;
  localparam logic [UPC_W-1:0] S_F_START   = 4'd3;
  localparam logic [UPC_W-1:0] S_F_SCAN    = 4'd4;
  localparam logic [UPC_W-1:0] S_F_CHECK   = 4'd5;
  localparam logic [UPC_W-1:0] S_SH_START  = 4'd6;
  localparam logic [UPC_W-1:0] S_SH_LOOP   = 4'd7;
  localparam logic [UPC_W-1:0] S_F_DONE    = 4'd8;
  localparam logic [UPC_W-1:0] S_F_MISS    = 4'd9;
  localparam logic [UPC_W-1:0] S_EMIT      = 4'd10;

  // Jump to target when cond holds, else advance (seq) or hold.
  function automatic ctl_word_t ucode(input logic [UPC_W-1:0] addr);
    ctl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, seq: 1'b0, target: S_WAIT};
    unique case (addr)
      S_WAIT:     w = '{op: OP_ACCEPT,    cond: C_IN_BEAT,  seq: 1'b0, target: S_DISPATCH};
      S_DISPATCH: w = '{op: OP_NOP,       cond: C_IS_FREE,  seq: 1'b1, target: S_F_START};
      S_ALLOC:    w = '{op: OP_ALLOC,     cond: C_ALWAYS,   seq: 1'b0, target: S_EMIT};
      S_F_START:  w = '{op: OP_RD_FIRST,  cond: C_CNT_ZERO, seq: 1'b1, target: S_F_MISS};
      S_F_SCAN:   w = '{op: OP_SCAN,      cond: C_SCAN_END, seq: 1'b0, target: S_F_CHECK};
      S_F_CHECK:  w = '{op: OP_NOP,       cond: C_NO_HIT,   seq: 1'b1, target: S_F_MISS};
      S_SH_START: w = '{op: OP_RD_NEXT,   cond: C_LAST1,    seq: 1'b1, target: S_F_DONE};
      S_SH_LOOP:  w = '{op: OP_SHIFT,     cond: C_LAST2,    seq: 1'b0, target: S_F_DONE};
      S_F_DONE:   w = '{op: OP_FREE_OK,   cond: C_ALWAYS,   seq: 1'b0, target: S_EMIT};
      S_F_MISS:   w = '{op: OP_FREE_MISS, cond: C_NEVER,    seq: 1'b1, target: S_EMIT};
      S_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_FREE, seq: 1'b0, target: S_WAIT};
      default: ;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bat_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bat_useq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on bat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bat_useq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bat_pkg::flags_t    flags,
  output      bat_pkg::ctl_word_t ctl
);

  logic [bat_pkg::UPC_W-1:0] upc_r;
  logic [bat_pkg::UPC_W-1:0] upc_nxt;
  logic                      jump;

  assign ctl = bat_pkg::ucode(upc_r);

  always_comb begin
    unique case (ctl.cond)
      bat_pkg::C_NEVER:    jump = 1'b0;
      bat_pkg::C_ALWAYS:   jump = 1'b1;
      bat_pkg::C_IN_BEAT:  jump = flags.in_beat;
      bat_pkg::C_IS_FREE:  jump = flags.is_free;
      bat_pkg::C_CNT_ZERO: jump = flags.cnt_zero;
      bat_pkg::C_SCAN_END: jump = flags.scan_end;
      bat_pkg::C_NO_HIT:   jump = flags.no_hit;
      bat_pkg::C_LAST1:    jump = flags.last1;
      bat_pkg::C_LAST2:    jump = flags.last2;
      bat_pkg::C_OUT_FREE: jump = flags.out_free;
      default:             jump = 1'b0;
    endcase
    if (jump) begin
      upc_nxt = ctl.target;
    end else if (ctl.seq) begin
      upc_nxt = upc_r + 1'b1;
    end else begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= bat_pkg::S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bat_dpath.sv @@
// Datapath: bump mark, live bytes, table count, block table RAM and result register.
// Depends on bat_pkg and bat_ram; driven by control words from bat_useq.
`timescale 1ns / 1ps
`default_nettype none

module bat_dpath #(
  parameter longint unsigned HEAP_BYTES    = 65536,
  parameter int              BLOCK_ENTRIES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bat_pkg::ctl_word_t            ctl,
  output      bat_pkg::flags_t               flags,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_action,
  input  wire logic [bat_pkg::FIELD_W-1:0]   in_request_size,
  input  wire logic [bat_pkg::FIELD_W-1:0]   in_free_offset,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [1:0]                    out_status,
  output      logic [bat_pkg::FIELD_W-1:0]   out_block_offset,
  output      logic                          out_compress_wanted
);

  localparam int FW = bat_pkg::FIELD_W;
  localparam int UW = $clog2(HEAP_BYTES + 1);
  localparam int MW = (UW > FW) ? UW : FW;
  localparam int SW = MW + 1;
  localparam int AW = $clog2(BLOCK_ENTRIES);
  localparam int CW = $clog2(BLOCK_ENTRIES + 1);
  localparam int DW = UW + FW;

  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] live_r, live_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          hit_r, hit_nxt;
  logic          act_r, act_nxt;
  logic [FW-1:0] req_r, req_nxt;
  logic [FW-1:0] off_r, off_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [FW-1:0] res_offset_r, res_offset_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [FW-1:0] out_offset_r, out_offset_nxt;
  logic          out_cw_r, out_cw_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [UW-1:0] rd_off;
  logic [FW-1:0] rd_size;

  logic          in_beat;
  logic          out_free;
  logic          hit_now;
  logic          alloc_ok;
  logic [CW:0]   ptr_ext;
  logic [CW:0]   cnt_ext;

  bat_ram #(
    .WIDTH (DW),
    .DEPTH (BLOCK_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_off   = ram_rdata[FW +: UW];
  assign rd_size  = ram_rdata[FW-1:0];
  assign in_stall = !rst_n || (ctl.op != bat_pkg::OP_ACCEPT);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign hit_now  = (MW'(rd_off) == MW'(off_r));
  assign alloc_ok = ((SW'(used_r) + SW'(req_r)) <= SW'(HEAP_BYTES)) &&
                    (count_r != CW'(BLOCK_ENTRIES));
  assign ptr_ext  = (CW+1)'(ptr_r);
  assign cnt_ext  = (CW+1)'(count_r);

  always_comb begin
    flags.in_beat  = in_beat;
    flags.is_free  = act_r;
    flags.cnt_zero = (count_r == '0);
    flags.last1    = (ptr_ext + (CW+1)'(1)) >= cnt_ext;
    flags.last2    = (ptr_ext + (CW+1)'(2)) >= cnt_ext;
    flags.scan_end = hit_now || flags.last1;
    flags.no_hit   = !hit_r;
    flags.out_free = out_free;
  end

  always_comb begin
    used_nxt       = used_r;
    live_nxt       = live_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    hit_nxt        = hit_r;
    act_nxt        = act_r;
    req_nxt        = req_r;
    off_nxt        = off_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r;
    unique case (ctl.op)
      bat_pkg::OP_ACCEPT: begin
        if (in_beat) begin
          act_nxt = in_action;
          req_nxt = in_request_size;
          off_nxt = in_free_offset;
          ptr_nxt = '0;
        end
      end
      bat_pkg::OP_ALLOC: begin
        if (alloc_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = count_r[AW-1:0];
          ram_wdata      = {used_r, req_r};
          count_nxt      = count_r + 1'b1;
          used_nxt       = used_r + UW'(req_r);
          live_nxt       = live_r + UW'(req_r);
          res_status_nxt = bat_pkg::ST_OK;
          res_offset_nxt = FW'(used_r);
        end else begin
          res_status_nxt = bat_pkg::ST_OVERFLOW;
          res_offset_nxt = '0;
        end
      end
      bat_pkg::OP_RD_FIRST: begin
        ram_raddr = ptr_r;
      end
      bat_pkg::OP_SCAN: begin
        ram_raddr = AW'(ptr_r + 1'b1);
        hit_nxt   = hit_now;
        if (hit_now) begin
          live_nxt = live_r - UW'(rd_size);
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      bat_pkg::OP_RD_NEXT: begin
        ram_raddr = AW'(ptr_r + 1'b1);
      end
      bat_pkg::OP_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ram_raddr = AW'(ptr_r + 2'd2);
        ptr_nxt   = ptr_r + 1'b1;
      end
      bat_pkg::OP_FREE_OK: begin
        count_nxt      = count_r - 1'b1;
        res_status_nxt = bat_pkg::ST_OK;
        res_offset_nxt = '0;
      end
      bat_pkg::OP_FREE_MISS: begin
        res_status_nxt = bat_pkg::ST_NOT_FOUND;
        res_offset_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_cw_nxt     = out_cw_r;
    if ((ctl.op == bat_pkg::OP_EMIT) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_offset_nxt = res_offset_r;
      out_cw_nxt     = {live_r, 1'b0} < {1'b0, used_r};
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      live_r      <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    req_r        <= req_nxt;
    off_r        <= off_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_cw_r     <= out_cw_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_block_offset    = out_offset_r;
  assign out_compress_wanted = out_cw_r;

endmodule

`default_nettype wire

@@ hw/rtl/bump_allocator_block_table_core.sv @@
// Bump allocator with a table of live blocks: top level.
// Depends on bat_pkg, bat_useq, bat_dpath (and bat_ram through bat_dpath).
//
// Usage:
//   Input beat (in_valid/in_stall): in_action 0 allocates in_request_size bytes at
//   the bump mark, 1 frees the table entry whose offset equals in_free_offset.
//   Result beat (out_valid/out_stall): out_status, out_block_offset and
//   out_compress_wanted (2*live < used after the update), one per input beat.
//   Items run one at a time through a microcoded sequencer over one table RAM.
//   Allocate: dispatch, allocate, then the emit step that loads the result.
//   Free of table entry k among n live entries: a scan up to entry k
//   (one entry a cycle), then the shift-down of later entries (one a cycle).
//   The next input beat is taken the cycle after the result is loaded, so a
//   finished result may still wait at the output while the next item runs.
//   Reset (synchronous) empties the table, clears the bump mark and drops any
//   pending result; in_stall stays high while rst_n is low.
//   A stalled result holds; the sequencer waits at its emit step while the
//   output register is still full.
`timescale 1ns / 1ps
`default_nettype none

module bump_allocator_block_table_core #(
  parameter longint unsigned HEAP_BYTES    = 65536,
  parameter int              BLOCK_ENTRIES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_action,
  input  wire logic [bat_pkg::FIELD_W-1:0] in_request_size,
  input  wire logic [bat_pkg::FIELD_W-1:0] in_free_offset,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [1:0]                  out_status,
  output      logic [bat_pkg::FIELD_W-1:0] out_block_offset,
  output      logic                        out_compress_wanted
);

  bat_pkg::ctl_word_t ctl;
  bat_pkg::flags_t    flags;

  bat_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  bat_dpath #(
    .HEAP_BYTES    (HEAP_BYTES),
    .BLOCK_ENTRIES (BLOCK_ENTRIES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .flags               (flags),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_request_size     (in_request_size),
    .in_free_offset      (in_free_offset),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_block_offset    (out_block_offset),
    .out_compress_wanted (out_compress_wanted)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    flags.in_beat |=> in_stall)
    else $error("input taken while an item is still in work");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == bat_pkg::OP_EMIT) && flags.out_free |=> out_valid)
    else $error("emit step did not load the result register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (ctl.op != bat_pkg::OP_EMIT) |=> !out_valid)
    else $error("result beat repeated");

endmodule

`default_nettype wire

@@ bench/bump_allocator_block_table_core_tb.sv @@
// Self-checking testbench for bump_allocator_block_table_core: allocate and free beats
// against a behavioral heap and block-table model, with idle and stall phases.
// Depends on bat_pkg and the bump_allocator_block_table_core RTL.
`timescale 1ns / 1ps

module bump_allocator_block_table_core_tb;

  localparam int FIELD_W = bat_pkg::FIELD_W;
  localparam longint unsigned HEAP_BYTES = 65536;
  localparam int BLOCK_ENTRIES = 64;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] block_offset;
    logic               compress_wanted;
  } heap_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_ALLOC;
  logic [FIELD_W-1:0] in_request_size = '0;
  logic [FIELD_W-1:0] in_free_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [FIELD_W-1:0] out_block_offset;
  logic out_compress_wanted;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  heap_answer_t expected_answers[$];

  longint unsigned heap_mark = 0;
  longint unsigned live_bytes = 0;
  int entry_count = 0;
  logic [FIELD_W-1:0] block_offsets[BLOCK_ENTRIES];
  logic [FIELD_W-1:0] block_lengths[BLOCK_ENTRIES];
  int n_alloc_ok = 0;
  int n_overflow = 0;
  int n_free_ok = 0;
  int n_free_miss = 0;
  int n_compress = 0;

  bump_allocator_block_table_core #(
    .HEAP_BYTES(HEAP_BYTES),
    .BLOCK_ENTRIES(BLOCK_ENTRIES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_request_size(in_request_size),
    .in_free_offset(in_free_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_block_offset(out_block_offset),
    .out_compress_wanted(out_compress_wanted)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH %s: got %0d expected %0d at %0t ns", what, got, want, $time);
    end
  endtask

  function automatic heap_answer_t predict_heap_answer(input logic act,
                                                       input logic [FIELD_W-1:0] req,
                                                       input logic [FIELD_W-1:0] off);
    heap_answer_t ans;
    int hit;
    ans = '{status: bat_pkg::ST_OK, block_offset: '0, compress_wanted: 1'b0};
    if (act == ACT_ALLOC) begin
      if (heap_mark + req > HEAP_BYTES || entry_count >= BLOCK_ENTRIES) begin
        ans.status = bat_pkg::ST_OVERFLOW;
        n_overflow++;
      end else begin
        ans.block_offset = FIELD_W'(heap_mark);
        block_offsets[entry_count] = FIELD_W'(heap_mark);
        block_lengths[entry_count] = req;
        entry_count++;
        heap_mark += req;
        live_bytes += req;
        n_alloc_ok++;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < entry_count; i++) begin
        if (hit < 0 && block_offsets[i] == off) hit = i;
      end
      if (hit < 0) begin
        ans.status = bat_pkg::ST_NOT_FOUND;
        n_free_miss++;
      end else begin
        live_bytes -= block_lengths[hit];
        for (int i = hit; i + 1 < entry_count; i++) begin
          block_offsets[i] = block_offsets[i + 1];
          block_lengths[i] = block_lengths[i + 1];
        end
        entry_count--;
        n_free_ok++;
      end
    end
    ans.compress_wanted = (2 * live_bytes < heap_mark);
    if (ans.compress_wanted) n_compress++;
    return ans;
  endfunction

  always @(posedge clk) begin : check_results
    heap_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = expected_answers.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_block_offset !== want.block_offset)
          report_mismatch("block_offset", int'(out_block_offset),
                          int'(want.block_offset));
        if (out_compress_wanted !== want.compress_wanted)
          report_mismatch("compress_wanted", int'(out_compress_wanted),
                          int'(want.compress_wanted));
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_item(input logic act, input logic [FIELD_W-1:0] req,
                           input logic [FIELD_W-1:0] off);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_request_size <= req;
    in_free_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_answers.push_back(predict_heap_answer(act, req, off));
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [FIELD_W-1:0] req);
    send_item(ACT_ALLOC, req, FIELD_W'($urandom));
  endtask

  task automatic send_free(input logic [FIELD_W-1:0] off);
    send_item(ACT_FREE, FIELD_W'($urandom), off);
  endtask

  function automatic logic [FIELD_W-1:0] live_offset();
    return block_offsets[$urandom_range(entry_count - 1)];
  endfunction

  task automatic test_empty_table();
    send_free('0);
    send_free(FIELD_MAX);
    send_alloc('0);
    send_free('0);
  endtask

  task automatic test_alloc_free();
    longint unsigned base;
    base = heap_mark;
    send_alloc(10);
    send_alloc(20);
    send_alloc(30);
    send_free(FIELD_W'(base + 10));
    send_free(FIELD_W'(base));
    send_free(FIELD_W'(base + 5));
    send_free(FIELD_W'(base + 30));
  endtask

  task automatic test_duplicate_offsets();
    longint unsigned base;
    base = heap_mark;
    send_alloc(0);
    send_alloc(0);
    send_alloc(7);
    repeat (4) send_free(FIELD_W'(base));
  endtask

  task automatic test_heap_exceeded();
    send_alloc(FIELD_MAX);
    send_alloc(17'd65537);
    send_alloc(FIELD_W'(HEAP_BYTES - heap_mark + 1));
    send_alloc(17'd65536);
    send_free(FIELD_MAX);
  endtask

  task automatic test_table_full();
    while (entry_count < BLOCK_ENTRIES) send_alloc(FIELD_W'($urandom_range(0, 3)));
    send_alloc('0);
    send_alloc(1);
    send_free(block_offsets[BLOCK_ENTRIES - 1]);
    send_free(block_offsets[0]);
    send_free(block_offsets[entry_count / 2]);
    while (entry_count > 0) send_free(live_offset());
  endtask

  task automatic send_random_item();
    int alloc_pct;
    int kind;
    logic [FIELD_W-1:0] req;
    alloc_pct = (entry_count < 16) ? 70 : ((entry_count > 56) ? 30 : 50);
    if ($urandom_range(99) < alloc_pct) begin
      kind = $urandom_range(99);
      if (kind < 80) req = FIELD_W'($urandom_range(1, 31));
      else if (kind < 88) req = '0;
      else if (kind < 95) req = FIELD_W'($urandom_range(32, 255));
      else req = FIELD_W'($urandom_range(65537, 131071));
      send_alloc(req);
    end else if (entry_count > 0 && $urandom_range(3) != 0) begin
      send_free(live_offset());
    end else if ($urandom_range(1) == 1) begin
      send_free(FIELD_W'($urandom));
    end else begin
      send_free(FIELD_W'($urandom_range(0, int'(heap_mark))));
    end
  endtask

  task automatic test_random_traffic();
    int idle_set[4] = '{0, 75, 0, 22};
    int stall_set[4] = '{0, 0, 75, 22};
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      repeat (500) send_random_item();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_heap_exhaust();
    while (entry_count > 60) send_free(live_offset());
    send_alloc(FIELD_W'(HEAP_BYTES - heap_mark));
    send_alloc(1);
    send_alloc('0);
    send_free(FIELD_W'(heap_mark));
    send_alloc(FIELD_MAX);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_table();
    test_alloc_free();
    test_duplicate_offsets();
    test_heap_exceeded();
    test_table_full();
    test_random_traffic();
    test_heap_exhaust();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Run covered %0d good allocations, %0d overflows, %0d frees, %0d unknown frees",
             n_alloc_ok, n_overflow, n_free_ok, n_free_miss);
    $display("%0d results flagged compaction; %0d field mismatches seen",
             n_compress, mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("bump_allocator_block_table_core verification clean");
    end else begin
      $display("bump_allocator_block_table_core verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bump_allocator_block_table_core verification failed");
    $finish;
  end

endmodule
